/* rtl/core/sfs_pkg.sv */
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants of the sprite frame sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned IN_TIME_W = 16;
  localparam int unsigned KIND_W    = 2;

  localparam logic [COORD_W-1:0] DEF_WIDTH  = 12'd32;
  localparam logic [COORD_W-1:0] DEF_HEIGHT = 12'd48;

  localparam logic [KIND_W-1:0] KIND_APPEND  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_DUR,
    ST_CMP,
    ST_RD_OUT,
    ST_OUT
  } sfs_state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } sfs_alu_op_t;

endpackage

/* rtl/core/sfs_time_alu.sv */
// ----------------------------------------------------------------------------
// sfs_time_alu
// Shared time unit: saturating add (flag is carry out), or subtract with borrow flag.
// ----------------------------------------------------------------------------
module sfs_time_alu #(
  parameter int unsigned W = 17
) (
  input  sfs_pkg::sfs_alu_op_t op,
  input  logic [W-1:0]         a,
  input  logic [W-1:0]         b,
  output logic [W-1:0]         res,
  output logic                 flag
);

  logic [W:0] wide;

  always_comb begin
    if (op == sfs_pkg::ALU_ADD) begin
      wide = {1'b0, a} + {1'b0, b};
      // saturate on carry out
      res  = wide[W] ? {W{1'b1}} : wide[W-1:0];
    end else begin
      wide = {1'b0, a} - {1'b0, b};
      res  = wide[W-1:0];
    end
    flag = wide[W];
  end

endmodule

/* rtl/core/sprite_frame_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_unit
// Sprite animation frame sequencer with frame table and time accumulator.
// ----------------------------------------------------------------------------
// Append, restart, an unused kind and an ignored tick pass EXEC, RD_OUT and OUT;
// a moving tick passes EXEC, then RD_DUR and CMP once per frame stepped and once
// more (not when it stops on the last frame), then RD_OUT and OUT. Items are taken
// only in IDLE; busy holds until the strobe has gone (one frame table, one unit).
// Reset (rst_n low, synchronous): empty table, index 0, time 0, not finished,
// loop enabled. The receiver cannot stall: each result is a one-cycle strobe.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_unit #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned TIME_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  // command beat
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_delta_time,
  input  logic [11:0] in_frame_left,
  input  logic [11:0] in_frame_top,
  input  logic [11:0] in_frame_width,
  input  logic [11:0] in_frame_height,
  input  logic [15:0] in_frame_duration,
  // result beat
  output logic        out_valid,
  output logic [11:0] out_rect_left,
  output logic [11:0] out_rect_top,
  output logic [11:0] out_rect_width,
  output logic [11:0] out_rect_height,
  output logic        out_done_res,
  output logic        out_append_rejected
);

  localparam int unsigned IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned ACC_W = TIME_BITS + 1;
  localparam int unsigned CW    = sfs_pkg::COORD_W;
  localparam int unsigned ENT_W = 4 * CW + TIME_BITS;
  // width that holds both the 16-bit port value and the stored time
  localparam int unsigned SAT_W = (TIME_BITS > sfs_pkg::IN_TIME_W) ?
                                  TIME_BITS : sfs_pkg::IN_TIME_W;
  localparam logic [SAT_W-1:0] TIME_MAX = SAT_W'((64'd1 << TIME_BITS) - 64'd1);

  // Controller state and registers
  sfs_pkg::sfs_state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ACC_W-1:0] elapsed_r, elapsed_nxt;
  logic             fin_r, fin_nxt;
  logic             rej_r, rej_nxt;
  logic             loop_r;

  // Latched command beat
  logic [1:0]           kind_r;
  logic [15:0]          delta_r;
  logic [4*CW-1:0]      rect_in_r;
  logic [15:0]          dur_in_r;

  // Frame table: {left, top, width, height, duration}
  logic [ENT_W-1:0] mem [MAX_FRAMES];
  logic [ENT_W-1:0] rd_data_r;
  logic             mem_we;
  logic [ENT_W-1:0] mem_wdata;

  // Shared time unit
  sfs_pkg::sfs_alu_op_t alu_op;
  logic [ACC_W-1:0]     alu_b;
  logic [ACC_W-1:0]     alu_res;
  logic                 alu_flag;

  // Saturated times
  logic [SAT_W-1:0]     delta_ext, dur_ext;
  logic [TIME_BITS-1:0] delta_sat, dur_sat, dur_store, dur_rd;
  logic                 last_frame;

  always_comb begin
    delta_ext = SAT_W'(delta_r);
    dur_ext   = SAT_W'(dur_in_r);
    delta_sat = (delta_ext > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0]
                                       : delta_ext[TIME_BITS-1:0];
    dur_sat   = (dur_ext > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0]
                                     : dur_ext[TIME_BITS-1:0];
    // a zero display time is stored as one
    dur_store = (dur_sat == '0) ? TIME_BITS'(1) : dur_sat;
    mem_wdata = {rect_in_r, dur_store};
    dur_rd    = rd_data_r[TIME_BITS-1:0];
    last_frame = (CNT_W'(idx_r) + CNT_W'(1)) == cnt_r;
  end

  sfs_time_alu #(
    .W(ACC_W)
  ) u_alu (
    .op  (alu_op),
    .a   (elapsed_r),
    .b   (alu_b),
    .res (alu_res),
    .flag(alu_flag)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_r <= 1'b1;
    end else if (cfg_we) begin
      loop_r <= cfg_wdata;
    end
  end

  // Latch the command beat on accept
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_r    <= in_kind;
      delta_r   <= in_delta_time;
      rect_in_r <= {in_frame_left, in_frame_top, in_frame_width, in_frame_height};
      dur_in_r  <= in_frame_duration;
    end
  end

  // Frame table write and registered read at the current index
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[IDX_W-1:0]] <= mem_wdata;
    end
    rd_data_r <= mem[idx_r];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sfs_pkg::ST_IDLE;
      idx_r     <= '0;
      cnt_r     <= '0;
      elapsed_r <= '0;
      fin_r     <= 1'b0;
      rej_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      cnt_r     <= cnt_nxt;
      elapsed_r <= elapsed_nxt;
      fin_r     <= fin_nxt;
      rej_r     <= rej_nxt;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    elapsed_nxt = elapsed_r;
    fin_nxt     = fin_r;
    rej_nxt     = rej_r;
    mem_we      = 1'b0;
    alu_op      = sfs_pkg::ALU_SUB;
    alu_b       = ACC_W'(dur_rd);

    case (state_r)
      sfs_pkg::ST_IDLE: begin
        if (start) begin
          rej_nxt   = 1'b0;
          state_nxt = sfs_pkg::ST_EXEC;
        end
      end
      sfs_pkg::ST_EXEC: begin
        state_nxt = sfs_pkg::ST_RD_OUT;
        case (kind_r)
          sfs_pkg::KIND_APPEND: begin
            if (cnt_r < CNT_W'(MAX_FRAMES)) begin
              mem_we  = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
            end else begin
              rej_nxt = 1'b1;
            end
          end
          sfs_pkg::KIND_TICK: begin
            // nothing moves on an empty table or a finished run
            if (!fin_r && (cnt_r != '0)) begin
              alu_op      = sfs_pkg::ALU_ADD;
              alu_b       = ACC_W'(delta_sat);
              elapsed_nxt = alu_res;
              state_nxt   = sfs_pkg::ST_RD_DUR;
            end
          end
          sfs_pkg::KIND_RESTART: begin
            idx_nxt     = '0;
            elapsed_nxt = '0;
            fin_nxt     = 1'b0;
          end
          default: begin
          end
        endcase
      end
      sfs_pkg::ST_RD_DUR: begin
        // wait for the duration of the current frame
        state_nxt = sfs_pkg::ST_CMP;
      end
      sfs_pkg::ST_CMP: begin
        if (alu_flag) begin
          // time left is below this frame's duration: hold here
          state_nxt = sfs_pkg::ST_RD_OUT;
        end else begin
          elapsed_nxt = alu_res;
          state_nxt   = sfs_pkg::ST_RD_DUR;
          if (last_frame) begin
            if (loop_r) begin
              idx_nxt = '0;
            end else begin
              // stop on the last frame and drop the leftover time
              fin_nxt     = 1'b1;
              elapsed_nxt = '0;
              state_nxt   = sfs_pkg::ST_RD_OUT;
            end
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      sfs_pkg::ST_RD_OUT: begin
        // wait for the rectangle of the current frame
        state_nxt = sfs_pkg::ST_OUT;
      end
      sfs_pkg::ST_OUT: begin
        state_nxt = sfs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = sfs_pkg::ST_IDLE;
      end
    endcase
  end

  // Result beat
  assign busy      = (state_r != sfs_pkg::ST_IDLE);
  assign out_valid = (state_r == sfs_pkg::ST_OUT);

  always_comb begin
    if (cnt_r == '0) begin
      out_rect_left   = '0;
      out_rect_top    = '0;
      out_rect_width  = sfs_pkg::DEF_WIDTH;
      out_rect_height = sfs_pkg::DEF_HEIGHT;
    end else begin
      out_rect_left   = rd_data_r[TIME_BITS+4*CW-1 -: CW];
      out_rect_top    = rd_data_r[TIME_BITS+3*CW-1 -: CW];
      out_rect_width  = rd_data_r[TIME_BITS+2*CW-1 -: CW];
      out_rect_height = rd_data_r[TIME_BITS+CW-1 -: CW];
    end
    out_done_res        = fin_r;
    out_append_rejected = rej_r;
  end

endmodule
